[sv/fio_pkg.sv]
// Shared types and constants for the fractal interpolation oscillator.
`timescale 1ns / 1ps
package fio_pkg;
    localparam int CFG_W = 17;
    localparam logic [1:0] REG_SHAPE = 2'd0;
    localparam logic [1:0] REG_WARP  = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;
    localparam logic signed [16:0] WARP_LIMIT = 17'sd64880;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BASE, ST_BUILD_RD, ST_BUILD_MUL, ST_BUILD_WR, ST_LAST,
        ST_PH, ST_MUL, ST_RD, ST_RD2, ST_INTERP, ST_OUT
    } state_t;

    typedef struct packed {
        logic start_build;  // set up counters, write first base entry
        logic base_step;    // write next base entry
        logic mul;          // form product
        logic wr_dst;       // write dst and advance
        logic wr_last;      // carry last point, swap
        logic phase;        // update phase
        logic pmul;
        logic rda;
        logic rdb;
        logic interp;
    } cmd_t;

    typedef struct packed {
        logic base_done;
        logic level_done;   // all points of level written
        logic build_done;   // all levels complete
    } sts_t;
endpackage

[sv/fio_datapath.sv]
// Datapath: wave stores, level builder, phase accumulator and interpolator.
`timescale 1ns / 1ps
module fio_datapath import fio_pkg::*; #(
    parameter int MAX_LEVELS  = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic                    shape,
    input  logic signed [16:0]      warp,
    input  logic [3:0]              depth,
    input  logic [PHASE_BITS-1:0]   step,
    input  logic                    sync,
    output logic [SAMPLE_BITS-1:0]  sample
);
    function automatic int depth_of(int l);
        int r;
        r = 1;
        for (int j = 0; j < l; j++) r = r * 3;
        return r + 1;
    endfunction
    localparam int DEPTH = depth_of(MAX_LEVELS);
    localparam int AW = $clog2(DEPTH + 1);
    localparam int SW = SAMPLE_BITS;
    localparam logic signed [SW+1:0] SMAX = (SW+2)'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [SW+1:0] SMIN = -(SW+2)'(64'sd1 <<< (SW-1));

    logic [SW-1:0] mem_a [DEPTH];
    logic [SW-1:0] mem_b [DEPTH];
    logic sel_reg;
    logic [AW-1:0] pts_reg, i_reg, np_reg;
    logic [1:0] t_reg;
    logic [3:0] lvl_reg, k_eff;
    logic [SW-1:0] rd_reg;
    logic signed [SW+17:0] prod_reg;
    logic [16:0] xq_reg;           // rounded x of the current point
    logic [AW+16:0] acc_reg;       // i*65536 + pts/2 remainder tracker
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS+AW-1:0] pp_reg;
    logic [1:0] n;

    assign n = shape ? 2'd3 : 2'd2;
    assign k_eff = (depth == 4'd0) ? 4'd1 :
                   (depth > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : depth;

    // base y at segment t: shape0 {0,1,0}; shape1 {0,1,1,0}
    function automatic logic base_y(logic s, logic [1:0] t);
        return (t == 2'd1) || (s && t == 2'd2);
    endfunction

    logic signed [2:0] c_val;
    assign c_val = 3'(base_y(shape, t_reg + 2'd1)) - 3'(base_y(shape, t_reg));

    logic [SW-1:0] rq;
    logic [SW-1:0] wdata;
    logic signed [SW+16:0] mul_w;
    logic signed [SW+17:0] f_val;
    logic signed [SW+17:0] y_full;
    logic signed [SW+17:0] dy;
    assign mul_w = $signed(rq) * warp;
    assign f_val = base_y(shape, t_reg) ? (SW+18)'(65536) : '0;
    assign dy = (prod_reg + 18'sh08000) >>> 16;
    assign y_full = dy + $signed({1'b0, xq_reg}) * c_val + f_val;
    assign wdata = (y_full > SMAX) ? SMAX[SW-1:0] :
                   (y_full < SMIN) ? SMIN[SW-1:0] : y_full[SW-1:0];

    logic [AW-1:0] ia, ib;
    assign ia = pp_reg[PHASE_BITS +: AW];
    assign ib = ia + 1'b1;
    logic [AW-1:0] raddr;
    // at the end of a level fetch src[pts], the point carried over unchanged
    assign raddr = cmd.rdb ? ib : (cmd.rda ? ia : (sts.level_done ? pts_reg : i_reg));

    always_ff @(posedge aclk) begin
        if (cmd.start_build)
            mem_a[0] <= '0;
        else if (cmd.base_step)
            mem_a[np_reg] <= base_y(shape, np_reg[1:0]) ? SW'(65536) : '0;
        else if ((cmd.wr_dst || cmd.wr_last) && !sel_reg)
            mem_b[np_reg] <= cmd.wr_last ? rq : wdata;
        else if ((cmd.wr_dst || cmd.wr_last) && sel_reg)
            mem_a[np_reg] <= cmd.wr_last ? rq : wdata;
        rq <= sel_reg ? mem_b[raddr] : mem_a[raddr];
    end

    // x step per point: 65536/pts as quotient and remainder; pts is n^lvl
    logic [16:0] q_step;
    logic [AW-1:0] r_step;
    always_comb begin
        q_step = 17'(32'd65536 >> lvl_reg);
        r_step = '0;
        if (shape) begin
            case (lvl_reg)
                4'd1: begin q_step = 17'(65536 / 3);     r_step = AW'(65536 % 3);     end
                4'd2: begin q_step = 17'(65536 / 9);     r_step = AW'(65536 % 9);     end
                4'd3: begin q_step = 17'(65536 / 27);    r_step = AW'(65536 % 27);    end
                4'd4: begin q_step = 17'(65536 / 81);    r_step = AW'(65536 % 81);    end
                4'd5: begin q_step = 17'(65536 / 243);   r_step = AW'(65536 % 243);   end
                4'd6: begin q_step = 17'(65536 / 729);   r_step = AW'(65536 % 729);   end
                4'd7: begin q_step = 17'(65536 / 2187);  r_step = AW'(65536 % 2187);  end
                4'd8: begin q_step = 17'(65536 / 6561);  r_step = AW'(65536 % 6561);  end
                4'd9: begin q_step = 17'(65536 / 19683); r_step = AW'(65536 % 19683); end
                default: begin q_step = '0; r_step = '0; end
            endcase
        end
    end

    // rounded x = floor((i*65536 + pts/2)/pts), stepped incrementally
    logic [AW+16:0] acc_n;
    logic [16:0] xq_n;
    always_comb begin
        acc_n = acc_reg + (AW+17)'(r_step);
        xq_n = xq_reg + q_step;
        if (acc_n >= (AW+17)'(pts_reg)) begin
            acc_n = acc_n - (AW+17)'(pts_reg);
            xq_n = xq_n + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0; pts_reg <= '0; phase_reg <= '0; lvl_reg <= '0;
            np_reg <= '0; i_reg <= '0; t_reg <= '0;
        end else begin
            if (cmd.start_build) begin
                sel_reg <= 1'b0; np_reg <= AW'(1); lvl_reg <= 4'd1;
                pts_reg <= AW'(n); i_reg <= '0; t_reg <= '0;
                xq_reg <= '0; acc_reg <= (AW+17)'(n >> 1);
            end
            if (cmd.base_step) begin
                if (np_reg == AW'(n)) begin
                    np_reg <= '0;
                end else np_reg <= np_reg + 1'b1;
            end
            if (cmd.mul) prod_reg <= {mul_w[SW+16], mul_w};
            if (cmd.wr_dst) begin
                np_reg <= np_reg + 1'b1;
                if (i_reg == pts_reg - 1'b1) begin
                    i_reg <= '0; t_reg <= t_reg + 1'b1;
                    xq_reg <= '0; acc_reg <= (AW+17)'(pts_reg >> 1);
                end else begin
                    i_reg <= i_reg + 1'b1; xq_reg <= xq_n; acc_reg <= acc_n;
                end
            end
            if (cmd.wr_last) begin
                sel_reg <= ~sel_reg; pts_reg <= AW'(pts_reg * n);
                lvl_reg <= lvl_reg + 1'b1; np_reg <= '0; i_reg <= '0; t_reg <= '0;
                xq_reg <= '0; acc_reg <= (AW+17)'((pts_reg * n) >> 1);
            end
            if (cmd.phase) phase_reg <= (sync ? '0 : phase_reg) + step;
            if (cmd.pmul) pp_reg <= phase_reg * pts_reg;
            if (cmd.rdb) rd_reg <= rq;
        end
    end

    // interpolate between t[i] (held) and t[i+1] (on the read port)
    logic [16:0] frac;
    logic signed [SW+18:0] ip;
    logic signed [SW+1:0] iv;
    assign frac = {1'b0, pp_reg[PHASE_BITS-1 -: 16]};
    assign ip = $signed(frac) * ($signed({rq[SW-1], rq}) - $signed({rd_reg[SW-1], rd_reg}));
    assign iv = $signed({{2{rd_reg[SW-1]}}, rd_reg}) + (SW+2)'((ip + 32768) >>> 16);
    always_ff @(posedge aclk) begin
        if (cmd.interp)
            sample <= (iv > SMAX) ? SMAX[SW-1:0] : (iv < SMIN) ? SMIN[SW-1:0] : iv[SW-1:0];
    end

    assign sts.base_done  = (np_reg == AW'(n));
    assign sts.level_done = (t_reg == n);
    assign sts.build_done = (lvl_reg >= k_eff);
endmodule

[sv/fio_ctrl.sv]
// Controller state machine sequencing rebuild and sample computation.
`timescale 1ns / 1ps
module fio_ctrl import fio_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_wr,
    input  logic in_beat,
    input  logic out_taken,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic out_valid
);
    state_t state_reg, state_next;
    logic pend_reg, pend_next, ov_reg, ov_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; pend_reg <= 1'b1; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; pend_reg <= pend_next; ov_reg <= ov_next;
        end
    end

    always_comb begin
        state_next = state_reg; cmd = '0;
        pend_next = pend_reg | cfg_wr;
        ov_next = ov_reg & ~out_taken;
        case (state_reg)
            ST_IDLE: if (in_beat) begin
                state_next = pend_reg ? ST_BASE : ST_PH;
                cmd.start_build = pend_reg;
            end
            ST_BASE: begin
                cmd.base_step = 1'b1;
                if (sts.base_done) state_next = ST_BUILD_RD;
            end
            ST_BUILD_RD: begin
                if (sts.build_done) begin
                    pend_next = cfg_wr; state_next = ST_PH;
                end else if (sts.level_done) state_next = ST_LAST;
                else state_next = ST_BUILD_MUL;
            end
            ST_BUILD_MUL: begin cmd.mul = 1'b1; state_next = ST_BUILD_WR; end
            ST_BUILD_WR:  begin cmd.wr_dst = 1'b1; state_next = ST_BUILD_RD; end
            ST_LAST:      begin cmd.wr_last = 1'b1; state_next = ST_BUILD_RD; end
            ST_PH:     begin cmd.phase = 1'b1; state_next = ST_MUL; end
            ST_MUL:    begin cmd.pmul = 1'b1; state_next = ST_RD; end
            ST_RD:     begin cmd.rda = 1'b1; state_next = ST_RD2; end
            ST_RD2:    begin cmd.rdb = 1'b1; state_next = ST_INTERP; end
            ST_INTERP: begin cmd.interp = 1'b1; state_next = ST_OUT; ov_next = 1'b1; end
            ST_OUT:    if (!ov_reg || out_taken) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end
    assign busy = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;
endmodule

[sv/fractal_interpolation_oscillator_unit.sv]
// Top level of the fractal interpolation wavetable oscillator.
`timescale 1ns / 1ps
// channel   | ports             | payload
// ----------+-------------------+---------------------------------
// input     | s_axis_t*         | tdata[31:0] phase_step, tuser sync_now
// result    | m_axis_t*         | tdata[23:0] sample_value
// config    | cfg_wr_*          | 0 core_shape, 1 warp_gain, 2 iteration_depth
// A sample steps from idle through phase, multiply, two table reads and
// interpolate to the output beat; no new item is accepted until it returns to idle.
// After reset or a config write the next beat first rebuilds the table: base writes,
// read/multiply/write per new point, read/carry per level, over one store port.
// aresetn is synchronous, active low. A stalled result holds the next beat.
module fractal_interpolation_oscillator_unit import fio_pkg::*; #(
    parameter int MAX_LEVELS  = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // phase_step
    input  logic        s_axis_tuser,   // sync_now
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // sample_value
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);
    logic shape_reg; logic signed [16:0] warp_reg; logic [3:0] depth_reg;
    logic [PHASE_BITS-1:0] step_reg; logic sync_reg;
    logic busy, cfg_hit;
    cmd_t cmd; sts_t sts;
    logic [SAMPLE_BITS-1:0] sample;

    assign cfg_hit = cfg_wr_en && (cfg_wr_index == REG_SHAPE ||
                     cfg_wr_index == REG_WARP || cfg_wr_index == REG_DEPTH);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= 1'b0; warp_reg <= 17'sd32768; depth_reg <= 4'd3;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SHAPE: shape_reg <= cfg_wr_data[0];
                // saturate warp to +-0.99
                REG_WARP: warp_reg <= ($signed(cfg_wr_data) > WARP_LIMIT) ? WARP_LIMIT :
                    ($signed(cfg_wr_data) < -WARP_LIMIT) ? -WARP_LIMIT : $signed(cfg_wr_data);
                REG_DEPTH: depth_reg <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;
    // latch the item at accept
    always_ff @(posedge aclk)
        if (s_axis_tvalid && s_axis_tready) begin
            step_reg <= PHASE_BITS'(s_axis_tdata);
            sync_reg <= s_axis_tuser;
        end

    fio_ctrl u_ctrl (.aclk, .aresetn, .cfg_wr(cfg_hit),
        .in_beat(s_axis_tvalid && s_axis_tready), .out_taken(m_axis_tready),
        .sts, .cmd, .busy, .out_valid(m_axis_tvalid));

    fio_datapath #(.MAX_LEVELS(MAX_LEVELS), .SAMPLE_BITS(SAMPLE_BITS),
        .PHASE_BITS(PHASE_BITS)) u_dp (.aclk, .aresetn, .cmd, .sts,
        .shape(shape_reg), .warp(warp_reg), .depth(depth_reg),
        .step(step_reg), .sync(sync_reg), .sample);

    // pad with zeros up to whole bytes
    assign m_axis_tdata = (((SAMPLE_BITS+7)/8)*8)'(sample);

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_axis_tready) else $error("accept while busy");
    a_warp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        warp_reg <= WARP_LIMIT && warp_reg >= -WARP_LIMIT) else $error("warp range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule

[verif/fractal_interpolation_oscillator_unit_tb.sv]
// Self-checking testbench for the fractal interpolation oscillator unit.
`timescale 1ns / 1ps
module fractal_interpolation_oscillator_unit_tb;
    import fio_pkg::*;

    localparam int TBL_DEPTH   = 6562;
    localparam int MAX_DEPTH   = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 230;   // per configuration phase

    typedef struct packed {
        logic [31:0] step;
        logic        sync;
    } tick_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_wr_index = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    fractal_interpolation_oscillator_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Oscillator predictor: its own copy of registers and wavetable
    // ---------------------------------------------------------------
    logic        shape_reg = 1'b0;
    int          warp_reg  = 32768;
    int          depth_reg = 3;
    int          wave_tbl [2][TBL_DEPTH];
    int          tbl_sel   = 0;
    longint      tbl_pts   = 0;
    logic [31:0] phase_acc = '0;
    bit          table_stale = 1'b1;

    tick_t       tick_q [$];     // ticks waiting for the driver
    logic [23:0] sample_q [$];   // predicted samples, oldest first
    int          errors = 0;
    bit          steady = 1'b0;  // suppress random idling on both sides
    int          cycles = 0;

    function automatic longint base_pt(input logic shape, input int i);
        if (i == 1) return 1;
        if (i == 2 && shape) return 1;
        return 0;
    endfunction

    // floor((v + 2^15) / 2^16)
    function automatic longint round16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic int sat24(input longint v);
        if (v > 64'sd8388607) return 8388607;
        if (v < -64'sd8388608) return -8388608;
        return int'(v);
    endfunction

    // Rebuild the wavetable from the current register copies.
    function automatic void rebuild_table();
        int     n;
        int     k;
        int     sel;
        int     np;
        longint pts;
        longint c;
        longint f;
        longint xq;
        n = shape_reg ? 3 : 2;
        k = depth_reg;
        sel = 0;
        pts = n;
        if (k < 1) k = 1;
        if (k > MAX_DEPTH) k = MAX_DEPTH;
        for (int i = 0; i <= n; i++) wave_tbl[0][i] = int'(base_pt(shape_reg, i) * 65536);
        for (int lvl = 2; lvl <= k; lvl++) begin
            np = 0;
            for (int t = 0; t < n; t++) begin
                c = base_pt(shape_reg, t + 1) - base_pt(shape_reg, t);
                f = base_pt(shape_reg, t) * 65536;
                for (longint i = 0; i < pts; i++) begin
                    xq = (i * 65536 + pts / 2) / pts;
                    wave_tbl[sel ^ 1][np] = sat24(c * xq
                        + round16(longint'(warp_reg) * longint'(wave_tbl[sel][i])) + f);
                    np++;
                end
            end
            wave_tbl[sel ^ 1][np] = wave_tbl[sel][pts];
            sel ^= 1;
            pts *= n;
        end
        tbl_sel = sel;
        tbl_pts = pts;
        table_stale = 1'b0;
    endfunction

    // Advance the phase for one accepted tick and queue the expected sample.
    function automatic void predict_sample(input tick_t tk);
        longint prod;
        longint idx;
        longint frac;
        longint a;
        longint b;
        longint v;
        int     s;
        if (table_stale) rebuild_table();
        if (tk.sync) phase_acc = '0;
        phase_acc = phase_acc + tk.step;
        prod = longint'({32'd0, phase_acc}) * tbl_pts;
        idx  = prod >>> 32;
        frac = (prod & 64'hFFFF_FFFF) >>> 16;
        a = wave_tbl[tbl_sel][idx];
        b = wave_tbl[tbl_sel][idx + 1];
        v = a + round16(frac * (b - a));
        s = sat24(v);
        sample_q.push_back(s[23:0]);
    endfunction

    // Mirror one register write; unknown indexes leave the table alone.
    function automatic void shadow_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        int w;
        case (idx)
            REG_SHAPE: begin
                shape_reg = data[0];
            end
            REG_WARP: begin
                w = int'($signed(data));
                if (w > int'(WARP_LIMIT)) w = int'(WARP_LIMIT);
                if (w < -int'(WARP_LIMIT)) w = -int'(WARP_LIMIT);
                warp_reg = w;
            end
            REG_DEPTH: begin
                depth_reg = int'(data[3:0]);
            end
            default: return;
        endcase
        table_stale = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Driver: hold a beat until taken, then pull the next tick
    // ---------------------------------------------------------------
    tick_t cur_tick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_sample(cur_tick);
            // random idle: roughly 18 percent of the time, none while steady
            if (tick_q.size() != 0 && (steady || $urandom_range(0, 99) >= 18)) begin
                cur_tick = tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur_tick.step;
                s_axis_tuser  <= cur_tick.sync;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random backpressure, compare each sample beat
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected sample beat, actual %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    if (m_axis_tdata !== sample_q[0]) begin
                        $display("%0t: sample_value mismatch, expected %h actual %h",
                                 $time, sample_q[0], m_axis_tdata);
                        errors++;
                    end
                    void'(sample_q.pop_front());
                end
            end
        end
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        shadow_write(idx, data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic push_tick(input logic [31:0] step, input logic sync);
        tick_t tk;
        tk.step = step;
        tk.sync = sync;
        tick_q.push_back(tk);
    endtask

    // Mostly random phase steps, some small ones to walk across neighboring entries.
    task automatic push_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                push_tick($urandom_range(0, 32'h000F_FFFF), $urandom_range(0, 9) == 0);
            else
                push_tick($urandom, $urandom_range(0, 9) == 0);
        end
    endtask

    // Hold off until the block has drained every beat, plus settle time.
    task automatic drain();
        while (tick_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ticks under the reset configuration (first beat rebuilds).
        push_tick(32'h0000_0000, 1'b0);
        push_tick(32'h0000_0001, 1'b0);
        push_tick(32'hFFFF_FFFF, 1'b0);
        push_tick(32'h8000_0000, 1'b0);
        push_tick(32'h8000_0000, 1'b0);   // wrap back to zero
        push_tick(32'h5555_5555, 1'b1);
        push_tick(32'hAAAA_AAAA, 1'b0);
        push_tick(32'hFFFF_FFFF, 1'b1);
        push_tick(32'h0000_FFFF, 1'b0);
        push_tick(32'h2AAA_AAAB, 1'b1);
        push_tick(32'h7FFF_FFFF, 1'b0);
        push_tick(32'h0000_0000, 1'b1);
        drain();

        // Deepest three-segment table, strongest positive warp; no idling here.
        steady = 1'b1;
        write_reg(REG_SHAPE, 17'd1);
        write_reg(REG_WARP, 17'sd64880);
        write_reg(REG_DEPTH, 17'd8);
        push_tick(32'hFFFF_FFFF, 1'b1);
        push_tick(32'h0000_0001, 1'b0);
        push_tick(32'h5555_5555, 1'b1);
        push_tick(32'h5555_5555, 1'b0);
        push_random(RAND_ITEMS);
        drain();
        steady = 1'b0;

        // Two segments, strongest negative warp, single level.
        write_reg(REG_SHAPE, 17'd0);
        write_reg(REG_WARP, -17'sd64880);
        write_reg(REG_DEPTH, 17'd1);
        push_random(RAND_ITEMS);
        drain();

        // Warp above the limit saturates; depth zero acts as one level.
        write_reg(REG_WARP, 17'sd65535);
        write_reg(REG_DEPTH, 17'd0);
        push_tick(32'h8000_0000, 1'b1);
        push_random(RAND_ITEMS);
        drain();

        // Warp below the limit, depth above the maximum, unknown index ignored.
        write_reg(REG_SHAPE, 17'd1);
        write_reg(REG_WARP, 17'h10000);
        write_reg(REG_DEPTH, 17'h1FFFF);
        write_reg(2'd3, 17'h1FFFF);
        push_random(RAND_ITEMS);
        drain();

        // Random moderate settings, then the same values written again.
        for (int p = 0; p < 2; p++) begin
            write_reg(REG_SHAPE, 17'($urandom_range(0, 1)));
            write_reg(REG_WARP, 17'($urandom));
            write_reg(REG_DEPTH, 17'($urandom_range(1, 5)));
            push_random(RAND_ITEMS);
            drain();
            write_reg(REG_SHAPE, {16'd0, shape_reg});
            write_reg(REG_WARP, 17'(warp_reg));
            write_reg(REG_DEPTH, 17'(depth_reg));
            push_random(RAND_ITEMS / 2);
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
